// ===== rtl/c2bp_pkg.sv =====
// c2bp_pkg: shared constants, types and helper functions of the cartesian to beam polar unit
// holds the arctangent table, the cordic lane word and the lane step functions
// no dependencies
package c2bp_pkg;

  localparam int COORD_WIDTH_DEF  = 24;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // angle accumulator in units of 2^-32 turn
  localparam int ACC_W = 32;
  // normalized magnitude sits in [2^39, 2^40)
  localparam int FRAME_W = 40;
  // cordic lane width, room for the gain and the quarter turn rotation
  localparam int XW = 43;
  // normalizing shift found as 32, 16, 8, 4, 2, 1
  localparam int NORM_STEPS = 6;

  localparam logic [ACC_W-1:0] QUARTER_TURN     = 32'h4000_0000;
  localparam logic [ACC_W-1:0] NEG_QUARTER_TURN = 32'hC000_0000;
  localparam logic [ACC_W-1:0] HALF_TURN        = 32'h8000_0000;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X = 2'd0,
    REG_CENTRE_Y = 2'd1,
    REG_CENTRE_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [FRAME_W-1:0]   m;
    logic [ACC_W-1:0]     acc;
    logic                 fixed;  // axis or origin, acc already exact
  } lane_t;

  // atan(2^-i) in units of 2^-32 turn, rounded
  function automatic logic [ACC_W-1:0] atan_turn(input int i);
    logic [ACC_W-1:0] t;
    case (i)
      0:  t = 32'h2000_0000;
      1:  t = 32'h12E4_051E;
      2:  t = 32'h09FB_385B;
      3:  t = 32'h0511_11D4;
      4:  t = 32'h028B_0D43;
      5:  t = 32'h0145_D7E1;
      6:  t = 32'h00A2_F61E;
      7:  t = 32'h0051_7C55;
      8:  t = 32'h0028_BE53;
      9:  t = 32'h0014_5F2F;
      10: t = 32'h000A_2F98;
      11: t = 32'h0005_17CC;
      12: t = 32'h0002_8BE6;
      13: t = 32'h0001_45F3;
      14: t = 32'h0000_A2FA;
      15: t = 32'h0000_517D;
      16: t = 32'h0000_28BE;
      17: t = 32'h0000_145F;
      18: t = 32'h0000_0A30;
      19: t = 32'h0000_0518;
      20: t = 32'h0000_028C;
      21: t = 32'h0000_0146;
      22: t = 32'h0000_00A3;
      23: t = 32'h0000_0051;
      default: t = '0;
    endcase
    return t;
  endfunction

  // load a vector (den, num), flag the axis and origin cases
  function automatic lane_t lane_entry(input logic signed [XW-1:0] num,
                                       input logic signed [XW-1:0] den);
    lane_t s;
    logic [XW-1:0] mn;
    logic [XW-1:0] md;
    mn = num[XW-1] ? (~num + 1'b1) : num;
    md = den[XW-1] ? (~den + 1'b1) : den;
    s.x = den;
    s.y = num;
    s.m = (mn > md) ? mn[FRAME_W-1:0] : md[FRAME_W-1:0];
    s.fixed = 1'b1;
    if (num == '0 && den == '0) begin
      s.acc = '0;
    end else if (den == '0) begin
      s.acc = num[XW-1] ? NEG_QUARTER_TURN : QUARTER_TURN;
    end else if (num == '0) begin
      s.acc = den[XW-1] ? HALF_TURN : '0;
    end else begin
      s.acc = '0;
      s.fixed = 1'b0;
    end
    return s;
  endfunction

  // one binary step of the normalizing shift
  function automatic lane_t lane_norm(input lane_t s, input int sh);
    lane_t r;
    r = s;
    if ((s.m >> (FRAME_W - sh)) == '0) begin
      r.m = s.m << sh;
      r.x = s.x <<< sh;
      r.y = s.y <<< sh;
    end
    return r;
  endfunction

  // rotate a vector in the left half plane by a quarter turn
  function automatic lane_t lane_prerot(input lane_t s);
    lane_t r;
    r = s;
    if (!s.fixed && s.x[XW-1]) begin
      if (!s.y[XW-1]) begin
        r.x = s.y;
        r.y = -s.x;
        r.acc = QUARTER_TURN;
      end else begin
        r.x = -s.y;
        r.y = s.x;
        r.acc = NEG_QUARTER_TURN;
      end
    end
    return r;
  endfunction

  // one vectoring micro-rotation, shifts round toward minus infinity
  function automatic lane_t lane_iter(input lane_t s, input int i);
    lane_t r;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    xs = $signed(s.x) >>> i;
    ys = $signed(s.y) >>> i;
    r = s;
    if (!s.y[XW-1]) begin
      r.x = s.x + ys;
      r.y = s.y - xs;
      if (!s.fixed) r.acc = s.acc + atan_turn(i);
    end else begin
      r.x = s.x - ys;
      r.y = s.y + xs;
      if (!s.fixed) r.acc = s.acc - atan_turn(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/c2bp_prep.sv =====
// c2bp_prep: centre subtraction with saturation (skipped when in_mode is 1), squares of x and z and their sum
// three register stages, advanced by a shared enable
// depends on c2bp_pkg
module c2bp_prep import c2bp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [COORD_WIDTH-1:0] in_x,
  input  logic [COORD_WIDTH-1:0] in_y,
  input  logic [COORD_WIDTH-1:0] in_z,
  input  logic                   in_mode,
  input  logic [COORD_WIDTH-1:0] centre_x,
  input  logic [COORD_WIDTH-1:0] centre_y,
  input  logic [COORD_WIDTH-1:0] centre_z,
  output logic                   out_valid,
  output logic [2*COORD_WIDTH-1:0] out_sq,
  output logic [COORD_WIDTH-1:0] out_x,
  output logic [COORD_WIDTH-1:0] out_y,
  output logic [COORD_WIDTH-1:0] out_z
);

  localparam int CW = COORD_WIDTH;

  function automatic logic [CW-1:0] sub_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] d;
    d = {a[CW-1], a} - {b[CW-1], b};
    if (d[CW] != d[CW-1]) begin
      return d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return d[CW-1:0];
  endfunction

  logic [2:0]      vld_r;
  logic [CW-1:0]   x0_r, y0_r, z0_r;
  logic [CW-1:0]   x1_r, y1_r, z1_r;
  logic [2*CW-1:0] sqx_r, sqz_r;
  logic [CW-1:0]   x2_r, y2_r, z2_r;
  logic [2*CW-1:0] sum_r;
  logic [CW-1:0]   ux, uz;

  assign ux = x0_r[CW-1] ? (~x0_r + 1'b1) : x0_r;
  assign uz = z0_r[CW-1] ? (~z0_r + 1'b1) : z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= in_mode ? in_x : sub_sat(in_x, centre_x);
      y0_r  <= in_mode ? in_y : sub_sat(in_y, centre_y);
      z0_r  <= in_mode ? in_z : sub_sat(in_z, centre_z);
      sqx_r <= ux * ux;
      sqz_r <= uz * uz;
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      z1_r  <= z0_r;
      sum_r <= sqx_r + sqz_r;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
    end
  end

  assign out_valid = vld_r[2];
  assign out_sq    = sum_r;
  assign out_x     = x2_r;
  assign out_y     = y2_r;
  assign out_z     = z2_r;

endmodule

// ===== rtl/c2bp_sqrt.sv =====
// c2bp_sqrt: pipelined integer square root, one result bit per stage, rounded to nearest
// carries a side word along so the coordinates stay aligned with the root
// depends on c2bp_pkg
module c2bp_sqrt import c2bp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int SIDE_W      = 3 * COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2*COORD_WIDTH-1:0] in_sq,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [COORD_WIDTH-1:0]   out_root,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int CW = COORD_WIDTH;

  logic [CW:0]     vld_r;
  logic [CW:0]     rem_r  [CW];
  logic [CW-1:0]   root_r [CW];
  logic [2*CW-1:0] sq_r   [CW];
  logic [SIDE_W-1:0] side_r [CW+1];
  logic [CW:0]     rem_nxt  [CW];
  logic [CW-1:0]   root_nxt [CW];
  logic [CW-1:0]   fin_root_r;
  logic [CW-1:0]   rounded;

  for (genvar j = 0; j < CW; j++) begin : g_digit
    logic [CW:0]     p_rem;
    logic [CW-1:0]   p_root;
    logic [2*CW-1:0] p_sq;
    logic [CW+2:0]   cur4;
    logic [CW+2:0]   trial;
    logic [CW+2:0]   diff;
    logic            take;
    if (j == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_sq   = in_sq;
    end else begin : g_next
      assign p_rem  = rem_r[j-1];
      assign p_root = root_r[j-1];
      assign p_sq   = sq_r[j-1];
    end
    assign cur4  = {p_rem, p_sq[2*CW-1 -: 2]};
    assign trial = {1'b0, p_root, 2'b01};
    assign take  = (cur4 >= trial);
    assign diff  = cur4 - trial;
    assign rem_nxt[j]  = take ? diff[CW:0] : cur4[CW:0];
    assign root_nxt[j] = {p_root[CW-2:0], take};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        sq_r[j]   <= p_sq << 2;
      end
    end
  end

  // round half up: remainder above the root means the true root is past q + 1/2
  assign rounded = (rem_r[CW-1] > {1'b0, root_r[CW-1]}) ? root_r[CW-1] + 1'b1 : root_r[CW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]  <= in_side;
      for (int s = 1; s <= CW; s++) begin
        side_r[s] <= side_r[s-1];
      end
      fin_root_r <= rounded;
    end
  end

  assign out_valid = vld_r[CW];
  assign out_root  = fin_root_r;
  assign out_side  = side_r[CW];

endmodule

// ===== rtl/c2bp_cordic.sv =====
// c2bp_cordic: two lockstep vectoring cordic lanes (azimuth and elevation)
// entry, six normalizing shift stages, quarter turn stage, one stage per iteration, rounding
// depends on c2bp_pkg
module c2bp_cordic import c2bp_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [XW-1:0]          phi_num,
  input  logic signed [XW-1:0]          phi_den,
  input  logic signed [XW-1:0]          theta_num,
  input  logic signed [XW-1:0]          theta_den,
  input  logic [COORD_WIDTH-1:0]        in_radius,
  output logic                          out_valid,
  output logic [COORD_WIDTH-1:0]        out_radius,
  output logic signed [ANGLE_WIDTH-1:0] out_phi,
  output logic signed [ANGLE_WIDTH-1:0] out_theta
);

  localparam int ITER_FIRST = NORM_STEPS + 2;
  localparam int NSTG       = ITER_FIRST + CORDIC_STEPS;
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (ACC_W - 1 - ANGLE_WIDTH);

  lane_t phi_r     [NSTG];
  lane_t theta_r   [NSTG];
  lane_t phi_nxt   [NSTG];
  lane_t theta_nxt [NSTG];
  logic [COORD_WIDTH-1:0] rad_r [NSTG];
  logic [NSTG-1:0]        vld_r;
  logic                   fin_vld_r;
  logic [COORD_WIDTH-1:0] fin_rad_r;
  logic [ANGLE_WIDTH-1:0] fin_phi_r, fin_theta_r;
  logic [ACC_W-1:0]       phi_sum, theta_sum;

  assign phi_nxt[0]   = lane_entry(phi_num, phi_den);
  assign theta_nxt[0] = lane_entry(theta_num, theta_den);

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STEPS - 1 - k);
    assign phi_nxt[k+1]   = lane_norm(phi_r[k], SH);
    assign theta_nxt[k+1] = lane_norm(theta_r[k], SH);
  end

  assign phi_nxt[NORM_STEPS+1]   = lane_prerot(phi_r[NORM_STEPS]);
  assign theta_nxt[NORM_STEPS+1] = lane_prerot(theta_r[NORM_STEPS]);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    assign phi_nxt[ITER_FIRST+i]   = lane_iter(phi_r[ITER_FIRST+i-1], i);
    assign theta_nxt[ITER_FIRST+i] = lane_iter(theta_r[ITER_FIRST+i-1], i);
  end

  // round half up to the output angle width, wraps modulo one turn
  assign phi_sum   = phi_r[NSTG-1].acc + HALF_LSB;
  assign theta_sum = theta_r[NSTG-1].acc + HALF_LSB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fin_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NSTG-2:0], in_valid};
      fin_vld_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NSTG; s++) begin
        phi_r[s]   <= phi_nxt[s];
        theta_r[s] <= theta_nxt[s];
      end
      rad_r[0] <= in_radius;
      for (int s = 1; s < NSTG; s++) begin
        rad_r[s] <= rad_r[s-1];
      end
      fin_rad_r   <= rad_r[NSTG-1];
      fin_phi_r   <= phi_sum[ACC_W-1 -: ANGLE_WIDTH];
      fin_theta_r <= theta_sum[ACC_W-1 -: ANGLE_WIDTH];
    end
  end

  assign out_valid  = fin_vld_r;
  assign out_radius = fin_rad_r;
  assign out_phi    = fin_phi_r;
  assign out_theta  = fin_theta_r;

endmodule

// ===== rtl/c2bp_outbuf.sv =====
// c2bp_outbuf: output register plus skid register in front of the result channel
// the pipeline enable comes from a flop, so no ready path runs through the stages
// depends on c2bp_pkg
module c2bp_outbuf import c2bp_pkg::*; #(
  parameter int WIDTH = COORD_WIDTH_DEF + 2 * ANGLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             en,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             hold_vld_r;
  logic             skid_vld_r;
  logic [WIDTH-1:0] hold_data_r;
  logic [WIDTH-1:0] skid_data_r;
  logic             take;

  assign en   = !skid_vld_r;
  assign take = hold_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) skid_vld_r <= 1'b0;
    end else if (in_valid) begin
      if (!hold_vld_r || take) begin
        hold_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (take) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (take) hold_data_r <= skid_data_r;
    end else if (in_valid) begin
      if (!hold_vld_r || take) begin
        hold_data_r <= in_data;
      end else begin
        skid_data_r <= in_data;
      end
    end
  end

  assign out_valid = hold_vld_r;
  assign out_data  = hold_data_r;

endmodule

// ===== rtl/cartesian_to_beam_polar_unit.sv =====
// cartesian_to_beam_polar_unit: top level of the cartesian to beam polar converter
// holds the centre registers and chains prep, square root, cordic and output buffer
// depends on c2bp_pkg, c2bp_prep, c2bp_sqrt, c2bp_cordic, c2bp_outbuf
//
// usage
//   input channel: in_valid/in_ready carry one position word (in_pos_x/y/z, in_mode)
//   result channel: out_valid/out_ready carry radius, azimuth phi and elevation theta
//   config port: cfg_we writes cfg_wdata into the centre register picked by cfg_index
//     (0 centre x, 1 centre y, 2 centre z, index 3 is ignored); write only while idle
//   in_mode 0 subtracts the centre first (saturated), in_mode 1 takes the word as is
//   angles are binary angles, 2^(ANGLE_WIDTH-1) is pi and shows as the most negative code
//   latency: COORD_WIDTH + CORDIC_STEPS + 14 cycles from accept to out_valid (54 by default),
//     set by one stage per root bit and one per cordic iteration
//   throughput: one word per cycle, every stage is a register and advances together
//   stall: results wait in an output register; a skid register takes one more word,
//     then in_ready drops until the receiver takes a result, nothing is lost or repeated
//   reset: synchronous, active low; clears all valid bits and the centre registers
module cartesian_to_beam_polar_unit import c2bp_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic                          in_mode,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_radius,
  output logic signed [ANGLE_WIDTH-1:0] out_phi,
  output logic signed [ANGLE_WIDTH-1:0] out_theta
);

  localparam int CW     = COORD_WIDTH;
  localparam int SIDE_W = 3 * CW;
  localparam int RES_W  = CW + 2 * ANGLE_WIDTH;

  // centre registers
  logic [CW-1:0] centre_x_r, centre_y_r, centre_z_r;

  // shared stage enable from the output buffer
  logic en;

  // prep to root
  logic            prep_valid;
  logic [2*CW-1:0] prep_sq;
  logic [CW-1:0]   prep_x, prep_y, prep_z;

  // root to cordic
  logic              root_valid;
  logic [CW-1:0]     root;
  logic [SIDE_W-1:0] root_side;
  logic [CW-1:0]     rx, ry, rz;

  // cordic to output buffer
  logic                   cor_valid;
  logic [CW-1:0]          cor_radius;
  logic [ANGLE_WIDTH-1:0] cor_phi, cor_theta;
  logic [RES_W-1:0]       res_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      centre_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE_X: centre_x_r <= cfg_wdata;
        REG_CENTRE_Y: centre_y_r <= cfg_wdata;
        REG_CENTRE_Z: centre_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input word is taken whenever the stages may advance
  assign in_ready = en;

  c2bp_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_x      (in_pos_x),
    .in_y      (in_pos_y),
    .in_z      (in_pos_z),
    .in_mode   (in_mode),
    .centre_x  (centre_x_r),
    .centre_y  (centre_y_r),
    .centre_z  (centre_z_r),
    .out_valid (prep_valid),
    .out_sq    (prep_sq),
    .out_x     (prep_x),
    .out_y     (prep_y),
    .out_z     (prep_z)
  );

  // the centred coordinates ride along the root pipeline
  c2bp_sqrt #(
    .COORD_WIDTH(COORD_WIDTH),
    .SIDE_W     (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_valid),
    .in_sq     (prep_sq),
    .in_side   ({prep_x, prep_y, prep_z}),
    .out_valid (root_valid),
    .out_root  (root),
    .out_side  (root_side)
  );

  assign rx = root_side[3*CW-1 -: CW];
  assign ry = root_side[2*CW-1 -: CW];
  assign rz = root_side[CW-1:0];

  // phi = atan2(x, z) from the beam axis, theta = atan2(y, radius)
  c2bp_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (root_valid),
    .phi_num    ({{(XW-CW){rx[CW-1]}}, rx}),
    .phi_den    ({{(XW-CW){rz[CW-1]}}, rz}),
    .theta_num  ({{(XW-CW){ry[CW-1]}}, ry}),
    .theta_den  ({{(XW-CW){1'b0}}, root}),
    .in_radius  (root),
    .out_valid  (cor_valid),
    .out_radius (cor_radius),
    .out_phi    (cor_phi),
    .out_theta  (cor_theta)
  );

  c2bp_outbuf #(
    .WIDTH(RES_W)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cor_valid),
    .in_data   ({cor_radius, cor_phi, cor_theta}),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_word)
  );

  assign out_radius = res_word[RES_W-1 -: CW];
  assign out_phi    = res_word[2*ANGLE_WIDTH-1 -: ANGLE_WIDTH];
  assign out_theta  = res_word[ANGLE_WIDTH-1:0];

endmodule
